/* rtl/csit_pkg.sv */
// ----------------------------------------------------------------------------
// csit_pkg: shared types and codes for the character sequence store
// Holds the action and status codes, the cell command set, the controller
// states and the control word that the controller broadcasts to every cell.
// ----------------------------------------------------------------------------
package csit_pkg;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_ERASE  = 2'd1;
	localparam logic [1:0] ACT_INSERT = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_APPEND,
		CMD_INSERT,
		CMD_ROTATE
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_INS,
		S_READ
	} state_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] value;
		logic [7:0] key;
	} cell_ctl_t;

endpackage

/* rtl/csit_cell.sv */
// ----------------------------------------------------------------------------
// csit_cell: one slot of the character row
// Holds one character and decides from the broadcast command, its own
// position and the current length whether it loads the new character, takes
// its left or right neighbor, or takes the head during a rotation.
// ----------------------------------------------------------------------------
module csit_cell #(
	parameter int LW  = 6,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  csit_pkg::cell_ctl_t  ctl,
	input  logic [LW-1:0]        len,
	input  logic                 first_left,
	input  logic                 above,
	input  logic [7:0]           left_data,
	input  logic [7:0]           right_data,
	input  logic [7:0]           head_data,
	output logic [7:0]           data,
	output logic                 match
);
	import csit_pkg::*;

	localparam logic [LW-1:0] IDX_L = LW'(IDX);
	localparam logic [LW-1:0] IDX_N = LW'(IDX + 1);

	logic [7:0] data_q;
	logic [7:0] data_d;

	assign data  = data_q;
	assign match = (IDX_L < len) && (data_q == ctl.key);

	always_comb begin
		data_d = data_q;
		case (ctl.cmd)
			CMD_APPEND: begin
				if (IDX_L == len) data_d = ctl.value;
			end
			CMD_INSERT: begin
				// The cell right after the first hit takes the new word; all
				// cells above it move one place toward the tail.
				if (first_left) data_d = ctl.value;
				else if (above) data_d = left_data;
			end
			CMD_ROTATE: begin
				if (IDX_N < len) data_d = right_data;
				else if (IDX_N == len) data_d = head_data;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

/* rtl/char_sequence_insert_truncate.sv */
// ----------------------------------------------------------------------------
// char_sequence_insert_truncate: bounded ordered store of byte characters
// Appends, erases from the tail, inserts after the first matching key and
// reads the whole sequence out, head first, over a row of cells.
// ----------------------------------------------------------------------------
// A new command is taken only in idle. An append, erase or empty read runs
// in the execute state; an insert runs in the execute state, which registers
// the per-cell key matches, then in the insert state, which applies the shift;
// a non-empty read goes on to the read state, where the row of cells rotates
// one place per cycle and the head cell gives one word per cycle while the
// result channel is not stalled. Each accepted word gives one result word,
// except a non-empty read: one per held character, last on the tail.
module char_sequence_insert_truncate #(
	parameter int DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [1:0] action,
	input  logic [7:0] value,
	input  logic [7:0] key,
	input  logic [5:0] count,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] status,
	output logic [7:0] element,
	output logic       last
);
	import csit_pkg::*;

	localparam int LW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = (LW > 6) ? LW : 6;
	localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

	state_t state_q, state_d;

	logic [1:0]       act_q;
	logic [7:0]       value_q;
	logic [7:0]       key_q;
	logic [5:0]       count_q;
	logic [LW-1:0]    len_q;
	logic [IW-1:0]    rd_cnt_q;
	logic [DEPTH-1:0] match_s1;

	logic             res_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       element_q;
	logic             last_q;

	logic [7:0]       cell_data [DEPTH];
	logic [DEPTH-1:0] match_vec;
	logic [DEPTH-1:0] low_incl;
	logic [DEPTH-1:0] first_hit;
	logic [DEPTH-1:0] above;
	cell_ctl_t        ctl;

	logic             accept;
	logic             out_free;
	logic             rd_last;
	logic [CW-1:0]    count_ext;
	logic [CW-1:0]    len_ext;

	// Output-side control from the controller.
	logic             produce;
	logic [1:0]       prod_status;
	logic [7:0]       prod_element;
	logic             prod_last;
	logic             len_inc;
	logic             len_erase;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign rd_last   = ((LW'(rd_cnt_q) + LW'(1)) == len_q);
	assign count_ext = CW'(count_q);
	assign len_ext   = CW'(len_q);

	// Lowest set bit of the registered match vector and the cells above it.
	assign low_incl  = match_s1 ^ (match_s1 - DEPTH'(1));
	assign first_hit = match_s1 & low_incl;
	assign above     = ~low_incl;

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [7:0] left_d;
			logic [7:0] right_d;
			logic       first_l;
			if (gi == 0) begin : g_head
				assign left_d  = 8'h00;
				assign first_l = 1'b0;
			end else begin : g_body
				assign left_d  = cell_data[gi-1];
				assign first_l = first_hit[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign right_d = 8'h00;
			end else begin : g_inner
				assign right_d = cell_data[gi+1];
			end
			csit_cell #(
				.LW  (LW),
				.IDX (gi)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.len        (len_q),
				.first_left (first_l),
				.above      (above[gi]),
				.left_data  (left_d),
				.right_data (right_d),
				.head_data  (cell_data[0]),
				.data       (cell_data[gi]),
				.match      (match_vec[gi])
			);
		end
	endgenerate

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (act_q)
					ACT_INSERT: state_d = S_INS;
					ACT_READ: begin
						if (len_q != '0) state_d = S_READ;
						else if (out_free) state_d = S_IDLE;
					end
					default: begin
						if (out_free) state_d = S_IDLE;
					end
				endcase
			end
			S_INS: begin
				if (out_free) state_d = S_IDLE;
			end
			S_READ: begin
				if (out_free && rd_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		ctl.cmd      = CMD_HOLD;
		ctl.value    = value_q;
		ctl.key      = key_q;
		produce      = 1'b0;
		prod_status  = ST_OK;
		prod_element = 8'h00;
		prod_last    = 1'b1;
		len_inc      = 1'b0;
		len_erase    = 1'b0;
		case (state_q)
			S_EXEC: begin
				case (act_q)
					ACT_APPEND: begin
						if (out_free) begin
							produce = 1'b1;
							if (len_q == DEPTH_L) begin
								prod_status = ST_FULL;
							end else begin
								ctl.cmd = CMD_APPEND;
								len_inc = 1'b1;
							end
						end
					end
					ACT_ERASE: begin
						if (out_free) begin
							produce   = 1'b1;
							len_erase = 1'b1;
						end
					end
					ACT_READ: begin
						if (len_q == '0 && out_free) begin
							produce     = 1'b1;
							prod_status = ST_EMPTY;
						end
					end
					default: ;
				endcase
			end
			S_INS: begin
				if (out_free) begin
					produce = 1'b1;
					if (match_s1 == '0) begin
						prod_status = ST_NOT_FOUND;
					end else if (len_q == DEPTH_L) begin
						prod_status = ST_FULL;
					end else begin
						ctl.cmd = CMD_INSERT;
						len_inc = 1'b1;
					end
				end
			end
			S_READ: begin
				if (out_free) begin
					produce      = 1'b1;
					prod_element = cell_data[0];
					prod_last    = rd_last;
					ctl.cmd      = CMD_ROTATE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			rd_cnt_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (len_inc) begin
				len_q <= len_q + LW'(1);
			end else if (len_erase) begin
				if (count_ext > len_ext) len_q <= '0;
				else len_q <= len_q - count_ext[LW-1:0];
			end
			if (state_q == S_EXEC) rd_cnt_q <= '0;
			else if (state_q == S_READ && out_free) rd_cnt_q <= rd_cnt_q + IW'(1);
			if (produce) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			value_q <= value;
			key_q   <= key;
			count_q <= count;
		end
		if (state_q == S_EXEC) match_s1 <= match_vec;
		if (produce) begin
			status_q  <= prod_status;
			element_q <= prod_element;
			last_q    <= prod_last;
		end
	end

`ifndef SYNTH
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= DEPTH_L)
		else $error("length exceeds depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> cmd_stall)
		else $error("new word taken while one is in progress");

	a_read_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && out_free && rd_last) |=> (state_q == S_IDLE))
		else $error("read did not finish on the tail character");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (len_q <= $past(len_q) || len_q == $past(len_q) + LW'(1)))
		else $error("length grew by more than one");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |-> !produce)
		else $error("result overwritten while stalled");
`endif

endmodule
